// File: hw/rtl/tssd_pkg.sv
// ----------------------------------------------------------------------------
// tssd_pkg
// Shared types and constants for the touch-strip step decoder.
// ----------------------------------------------------------------------------
package tssd_pkg;

  // Widths of the report fields and of the position tracker
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned POS_W    = 13;
  localparam int unsigned THR_W    = 7;
  localparam int unsigned CODE_W   = 3;
  localparam int unsigned CFG_IDX_W = 2;

  // Reset values of the configuration registers
  localparam logic             MODE_RESET = 1'b1;
  localparam logic [THR_W-1:0] THR_RESET  = 7'd80;

  // Report mode encoding
  localparam logic MODE_ABSOLUTE = 1'b0;

  // Header bits 4:3 must both be set for a valid relative report
  localparam logic [BYTE_W-1:0] HDR_REL_MASK = 8'h18;
  localparam logic [BYTE_W-1:0] STS_POS_MASK = 8'hf0;
  localparam logic [BYTE_W-1:0] PRS_MASK     = 8'h3f;
  localparam logic [BYTE_W-1:0] STS_CLICK    = 8'h02;

  // Zone bounds on the remembered absolute position
  localparam logic signed [POS_W-1:0] ZONE1_LO = 13'sd100;
  localparam logic signed [POS_W-1:0] ZONE1_HI = 13'sd1300;
  localparam logic signed [POS_W-1:0] ZONE2_LO = 13'sd1430;
  localparam logic signed [POS_W-1:0] ZONE2_HI = 13'sd2660;
  localparam logic signed [POS_W-1:0] ZONE3_LO = 13'sd2800;

  // Result step codes
  typedef enum logic [CODE_W-1:0] {
    STEP_NONE    = 3'd0,
    STEP_BACK    = 3'd1,
    STEP_CLEARED = 3'd2,
    STEP_FWD     = 3'd3,
    STEP_ZONE2   = 3'd4,
    STEP_ZONE3   = 3'd5
  } step_code_t;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_REPORT_MODE    = 2'd0,
    CFG_STEP_THRESHOLD = 2'd1
  } cfg_idx_t;

  // One report, header in the low byte
  typedef struct packed {
    logic [BYTE_W-1:0] pressure_byte;
    logic [BYTE_W-1:0] position_byte;
    logic [BYTE_W-1:0] status_byte;
    logic [BYTE_W-1:0] header_byte;
  } item_t;

  // One result, step code in the low bits
  typedef struct packed {
    logic       gesture_end;
    logic       gesture_start;
    logic       click_seen;
    step_code_t step_code;
  } result_t;

  // Gesture tracking state
  typedef struct packed {
    logic                    start_flag;
    logic                    active_flag;
    logic                    end_flag;
    logic signed [POS_W-1:0] current_position;
  } track_t;

  // Configuration register set
  typedef struct packed {
    logic             report_mode;
    logic [THR_W-1:0] step_threshold;
  } cfg_t;

endpackage

// File: hw/rtl/tssd_decode.sv
// ----------------------------------------------------------------------------
// tssd_decode
// Decodes one report against the current tracking state and produces the
// result item and the next tracking state.
// ----------------------------------------------------------------------------
module tssd_decode (
  input  tssd_pkg::item_t   item,
  input  tssd_pkg::track_t  trk,
  input  tssd_pkg::cfg_t    cfg,
  output tssd_pkg::result_t res,
  output tssd_pkg::track_t  trk_nxt
);
  import tssd_pkg::*;

  localparam int unsigned SUM_W = POS_W + 1;

  logic                    absolute;
  logic                    hdr_ok;
  logic                    finger;
  logic [5:0]              pressure;
  logic signed [POS_W-1:0] x;
  logic                    click;
  logic                    x_zero;
  logic                    s_n, a_n, e_n;
  logic                    is_start;
  logic signed [POS_W-1:0] p;
  logic signed [SUM_W-1:0] sum;
  logic signed [SUM_W-1:0] thr_pos;
  logic signed [SUM_W-1:0] thr_neg;
  step_code_t              code;
  logic signed [POS_W-1:0] pos_nxt;

  // Field extraction
  always_comb begin
    absolute = (cfg.report_mode == MODE_ABSOLUTE);
    hdr_ok   = ((item.header_byte & HDR_REL_MASK) == HDR_REL_MASK);
    finger   = item.position_byte[0];
    pressure = 6'(item.pressure_byte & PRS_MASK);
    if (absolute) begin
      x     = $signed({1'b0, 4'((item.status_byte & STS_POS_MASK) >> 4),
                       item.position_byte});
      click = ((item.status_byte & STS_CLICK) != '0);
    end else if (hdr_ok) begin
      x     = $signed({{(POS_W-BYTE_W){item.position_byte[BYTE_W-1]}},
                       item.position_byte});
      click = ((item.status_byte & STS_CLICK) != '0);
    end else begin
      x     = '0;
      click = 1'b0;
    end
    x_zero = (x == '0);
  end

  // Gesture flags
  always_comb begin
    s_n = trk.start_flag;
    a_n = trk.active_flag;
    e_n = trk.end_flag;
    if (absolute) begin
      if (x_zero && !click && pressure == '0 && !finger) begin
        if (trk.start_flag) begin
          e_n = 1'b1; s_n = 1'b0; a_n = 1'b0;
        end else begin
          s_n = 1'b1; a_n = 1'b0; e_n = 1'b0;
        end
      end else begin
        a_n = 1'b1;
      end
    end else if (hdr_ok) begin
      if (x_zero && !click && !finger) begin
        if (trk.start_flag && trk.active_flag) begin
          e_n = 1'b1; s_n = 1'b0; a_n = 1'b0;
        end else begin
          s_n = 1'b1; a_n = 1'b0; e_n = 1'b0;
        end
      end else if (!trk.start_flag && trk.end_flag) begin
        s_n = 1'b1; e_n = 1'b0; a_n = 1'b0;
      end else begin
        a_n = 1'b1;
      end
    end
    is_start = s_n && !a_n;
  end

  // Position tracking, zones and steps
  always_comb begin
    p       = is_start ? '0 : trk.current_position;
    sum     = SUM_W'(p) + SUM_W'(x);
    thr_pos = $signed({{(SUM_W-THR_W){1'b0}}, cfg.step_threshold});
    thr_neg = -thr_pos;
    code    = STEP_NONE;
    pos_nxt = p;
    if (click) begin
      code = STEP_CLEARED;
      if (absolute) begin
        if (p < ZONE1_HI && p > ZONE1_LO) code = STEP_FWD;
        else if (p > ZONE2_LO && p < ZONE2_HI) code = STEP_ZONE2;
        else if (p > ZONE3_LO) code = STEP_ZONE3;
      end
      pos_nxt = '0;
    end else if (absolute) begin
      if (!x_zero) pos_nxt = x;
    end else begin
      // a step resets the position, so it stays within +/- the threshold
      if (sum > thr_pos) begin
        code    = STEP_FWD;
        pos_nxt = '0;
      end else if (sum < thr_neg) begin
        code    = STEP_BACK;
        pos_nxt = '0;
      end else begin
        pos_nxt = sum[POS_W-1:0];
      end
    end
    // empty report overrides the step code
    if (x_zero && !click) code = STEP_CLEARED;
  end

  assign res.step_code     = code;
  assign res.click_seen    = click;
  assign res.gesture_start = is_start;
  assign res.gesture_end   = e_n;

  assign trk_nxt.start_flag       = s_n;
  assign trk_nxt.active_flag      = a_n;
  assign trk_nxt.end_flag         = e_n;
  assign trk_nxt.current_position = pos_nxt;

endmodule

// File: hw/rtl/touch_strip_step_decoder_core.sv
// ----------------------------------------------------------------------------
// touch_strip_step_decoder_core
// Touch-strip report decoder: gesture flags, click zones and relative steps.
// ----------------------------------------------------------------------------
// Pipeline: input register, then result register; a stalled result waits.
// Throughput: one request per cycle while the result stage is not stalled;
//   the gesture state updates as a request leaves the input register, so
//   the next request sees it at once.
// Reset: rst_n synchronous, active low; clears valids and gesture state and
//   loads report_mode = 1 (relative) and step_threshold = 80.
module touch_strip_step_decoder_core (
  input  logic                              clk,
  input  logic                              rst_n,
  // in_tdata: header_byte[7:0], status_byte[15:8], position_byte[23:16],
  //           pressure_byte[31:24]
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [31:0]                       in_tdata,
  // out_tdata: step_code[2:0], click_seen[3], gesture_start[4],
  //            gesture_end[5], zero[7:6]
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [7:0]                        out_tdata,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [tssd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [tssd_pkg::THR_W-1:0]        cfg_data
);
  import tssd_pkg::*;

  cfg_t    cfg_r;
  logic    in_valid_r;
  item_t   in_item_r;
  logic    out_valid_r;
  result_t out_res_r;
  track_t  trk_r;
  track_t  trk_nxt;
  result_t res;
  logic    advance;

  // Move a request to the result stage when that stage is free or draining
  assign advance   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;
  assign cfg_ready = 1'b1;

  tssd_decode u_decode (
    .item    (in_item_r),
    .trk     (trk_r),
    .cfg     (cfg_r),
    .res     (res),
    .trk_nxt (trk_nxt)
  );

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.report_mode    <= MODE_RESET;
      cfg_r.step_threshold <= THR_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_idx_t'(cfg_index))
        CFG_REPORT_MODE:    cfg_r.report_mode    <= cfg_data[0];
        CFG_STEP_THRESHOLD: cfg_r.step_threshold <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) in_item_r <= item_t'(in_tdata);
  end

  // Gesture state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      trk_r <= '0;
    end else if (advance) begin
      trk_r <= trk_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) out_res_r <= res;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_res_r};

endmodule

// File: hw/rtl/tssd_checker.sv
// ----------------------------------------------------------------------------
// tssd_checker
// Port-level checks on the step decoder's result stream.
// ----------------------------------------------------------------------------
module tssd_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata
);
  import tssd_pkg::*;

  // Nothing comes out in the cycle after reset
  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  // A stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

  // Step code stays within its codes
  a_code_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[2:0] <= STEP_ZONE3)
    else $error("step code out of range");

  // A click never gives a back step or no step
  a_click_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[3] |-> out_tdata[2:0] >= STEP_CLEARED)
    else $error("click with back or no step code");

  // Start and end of a gesture never show together
  a_start_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tdata[4] && out_tdata[5]))
    else $error("gesture start and end both set");

endmodule

bind touch_strip_step_decoder_core tssd_checker u_tssd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

// File: test/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the touch-strip step decoder. A driver feeds
// queued reports and a monitor checks every result against a predictor
// that tracks gesture flags, click zones and the relative step sum.
// ----------------------------------------------------------------------------
module tb_top;
  import tssd_pkg::*;

  localparam int unsigned LIMIT_CYCLES = 200000;
  localparam int unsigned RAND_PHASES  = 8;
  localparam int unsigned PHASE_ITEMS  = 75;

  logic                 clk        = 1'b0;
  logic                 rst_n      = 1'b0;
  logic                 in_tvalid  = 1'b0;
  logic                 in_tready;
  logic [31:0]          in_tdata   = '0;
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [7:0]           out_tdata;
  logic                 cfg_valid  = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index  = '0;
  logic [THR_W-1:0]     cfg_data   = '0;

  touch_strip_step_decoder_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Predictor copy of the registers and the gesture tracker
  logic                    mode_r   = MODE_RESET;
  logic [THR_W-1:0]        thr_r    = THR_RESET;
  logic                    g_start  = 1'b0;
  logic                    g_active = 1'b0;
  logic                    g_end    = 1'b0;
  logic signed [POS_W-1:0] g_pos    = '0;

  item_t   report_q[$];
  result_t step_q[$];
  int      in_idle_pct   = 0;
  int      out_stall_pct = 0;
  int      fail_cnt      = 0;
  bit      in_taken      = 1'b0;

  // Positions on and around the zone bounds
  int unsigned zone_marks[12] = '{0, 100, 101, 1299, 1300, 1430, 1431,
                                  2659, 2660, 2800, 2801, 4095};

  // Clock
  initial begin
    forever #2 clk = ~clk;
  end

  // Decode one report and update the tracker; returns the expected result
  function automatic result_t decode_report(item_t r);
    result_t          res;
    int               x;
    int               p;
    int               sum;
    int               thr;
    logic             click;
    logic             finger;
    logic             is_start;
    logic             absolute;
    logic [BYTE_W-1:0] z;
    logic [BYTE_W-1:0] hi;
    step_code_t       code;
    x        = 0;
    click    = 1'b0;
    code     = STEP_NONE;
    absolute = (mode_r == MODE_ABSOLUTE);
    if (absolute) begin
      z      = r.pressure_byte & PRS_MASK;
      finger = r.position_byte[0];
      hi     = r.status_byte & STS_POS_MASK;
      x      = (int'(hi) << 4) | int'(r.position_byte);
      click  = |(r.status_byte & STS_CLICK);
      if (x == 0 && !click && z == '0 && !finger) begin
        if (g_start) begin
          g_end = 1'b1; g_start = 1'b0; g_active = 1'b0;
        end else begin
          g_start = 1'b1; g_active = 1'b0; g_end = 1'b0;
        end
      end else begin
        g_active = 1'b1;
      end
    end else if ((r.header_byte & HDR_REL_MASK) == HDR_REL_MASK) begin
      finger = r.position_byte[0];
      x      = int'($signed(r.position_byte));
      click  = |(r.status_byte & STS_CLICK);
      if (x == 0 && !click && !finger) begin
        if (g_start && g_active) begin
          g_end = 1'b1; g_start = 1'b0; g_active = 1'b0;
        end else begin
          g_start = 1'b1; g_active = 1'b0; g_end = 1'b0;
        end
      end else if (!g_start && g_end) begin
        g_start = 1'b1; g_end = 1'b0; g_active = 1'b0;
      end else begin
        g_active = 1'b1;
      end
    end

    // A fresh gesture drops the remembered position first
    is_start = g_start && !g_active;
    if (is_start) g_pos = '0;

    if (click) begin
      code = STEP_CLEARED;
      if (absolute) begin
        p = int'(g_pos);
        if (p < int'(ZONE1_HI) && p > int'(ZONE1_LO)) code = STEP_FWD;
        else if (p > int'(ZONE2_LO) && p < int'(ZONE2_HI)) code = STEP_ZONE2;
        else if (p > int'(ZONE3_LO)) code = STEP_ZONE3;
      end
      g_pos = '0;
    end else if (absolute) begin
      if (x != 0) g_pos = POS_W'(x);
    end else begin
      thr = int'(thr_r);
      sum = int'(g_pos) + x;
      if (sum > thr) begin
        code = STEP_FWD;
        sum  = 0;
      end else if (sum < -thr) begin
        code = STEP_BACK;
        sum  = 0;
      end
      g_pos = POS_W'(sum);
    end

    // Empty report overrides any code
    if (x == 0 && !click) code = STEP_CLEARED;

    res.step_code     = code;
    res.click_seen    = click;
    res.gesture_start = is_start;
    res.gesture_end   = g_end;
    return res;
  endfunction

  // Random report, mostly well formed for the given mode
  function automatic item_t make_report(logic absolute);
    item_t       r;
    int unsigned kind;
    int unsigned p;
    r    = item_t'($urandom);
    kind = $urandom_range(99);
    if (absolute) begin
      if (kind < 20) begin
        // empty report, only don't-care bits random
        r.status_byte   = r.status_byte & ~(STS_POS_MASK | STS_CLICK);
        r.position_byte = '0;
        r.pressure_byte = r.pressure_byte & ~PRS_MASK;
      end else if (kind < 45) begin
        r.status_byte = r.status_byte | STS_CLICK;
      end else if (kind < 85) begin
        p = ($urandom_range(99) < 30) ? zone_marks[$urandom_range(11)]
                                      : $urandom_range(4095);
        r.status_byte   = (r.status_byte & ~(STS_POS_MASK | STS_CLICK)) |
                          {4'(p >> 8), 4'h0};
        r.position_byte = 8'(p);
      end
    end else begin
      if (kind < 15) begin
        r.header_byte   = r.header_byte | HDR_REL_MASK;
        r.status_byte   = r.status_byte & ~STS_CLICK;
        r.position_byte = '0;
      end else if (kind < 25) begin
        // broken header: at most one of bits 4:3 set
        if ((r.header_byte & HDR_REL_MASK) == HDR_REL_MASK)
          r.header_byte[$urandom_range(4, 3)] = 1'b0;
      end else if (kind < 35) begin
        r.header_byte = r.header_byte | HDR_REL_MASK;
        r.status_byte = r.status_byte | STS_CLICK;
      end else if (kind < 90) begin
        r.header_byte = r.header_byte | HDR_REL_MASK;
        r.status_byte = r.status_byte & ~STS_CLICK;
      end
    end
    return r;
  endfunction

  task automatic push_report(logic [7:0] h, logic [7:0] s, logic [7:0] p,
                             logic [7:0] z);
    item_t r;
    r.header_byte   = h;
    r.status_byte   = s;
    r.position_byte = p;
    r.pressure_byte = z;
    report_q.push_back(r);
  endtask

  // Register write while the block is idle
  task automatic write_reg(cfg_idx_t idx, logic [THR_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_REPORT_MODE) mode_r = val[0];
    else thr_r = val;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Wait until every request has gone through and its result has come back
  task automatic wait_drained();
    do @(negedge clk); while (report_q.size() != 0 || in_tvalid || step_q.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  // Request driver and result-side backpressure
  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= out_stall_pct);
    if (!in_tvalid || in_taken) begin
      in_taken = 1'b0;
      if (rst_n && report_q.size() != 0 && $urandom_range(99) >= in_idle_pct) begin
        in_tdata  <= report_q.pop_front();
        in_tvalid <= 1'b1;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Monitor: predict on accept, check on result
  always @(posedge clk) begin
    result_t exp_r;
    if (rst_n && out_tvalid && out_tready) begin
      if (step_q.size() == 0) begin
        fail_cnt++;
        if (fail_cnt <= 10) $display("unexpected result %h", out_tdata);
      end else begin
        exp_r = step_q.pop_front();
        if (out_tdata !== {2'b00, exp_r}) begin
          fail_cnt++;
          if (fail_cnt <= 10)
            $display({"wrong result: exp code %0d click %0b start %0b end %0b,",
                      " got code %0d click %0b start %0b end %0b (raw %h)"},
                     exp_r.step_code, exp_r.click_seen, exp_r.gesture_start,
                     exp_r.gesture_end, out_tdata[2:0], out_tdata[3],
                     out_tdata[4], out_tdata[5], out_tdata);
        end
      end
    end
    if (rst_n && in_tvalid && in_tready) begin
      step_q.push_back(decode_report(item_t'(in_tdata)));
      in_taken = 1'b1;
    end
  end

  // Run limit
  initial begin
    int unsigned cyc;
    cyc = 0;
    while (cyc < LIMIT_CYCLES) begin
      @(posedge clk);
      cyc++;
    end
    $display("touch_strip_step_decoder_core: mismatch");
    $finish;
  end

  // Stimulus
  initial begin
    logic             mode;
    logic [THR_W-1:0] thr;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    // Relative mode with reset settings: steps, gesture end, click, bad header
    push_report(8'h18, 8'h00, 8'h00, 8'h00);
    push_report(8'hff, 8'hfd, 8'h7f, 8'hff);
    push_report(8'h18, 8'h00, 8'h80, 8'h00);
    push_report(8'h18, 8'h00, 8'h80, 8'h00);
    push_report(8'h18, 8'h00, 8'h00, 8'h00);
    push_report(8'h18, 8'h00, 8'h00, 8'h00);
    push_report(8'h18, 8'h02, 8'h05, 8'h00);
    push_report(8'h10, 8'h00, 8'h40, 8'h00);
    push_report(8'h08, 8'h02, 8'h40, 8'h00);
    push_report(8'h18, 8'h00, 8'h01, 8'h00);
    wait_drained();

    // Absolute mode: zones, outside click, zero position held
    write_reg(CFG_REPORT_MODE, THR_W'(MODE_ABSOLUTE));
    push_report(8'h00, 8'h00, 8'h00, 8'h00);
    push_report(8'h00, 8'hf0, 8'hff, 8'h00);
    push_report(8'h00, 8'h00, 8'h00, 8'h3f);
    push_report(8'h00, 8'h02, 8'h00, 8'h00);
    push_report(8'h00, 8'h10, 8'hf4, 8'h00);
    push_report(8'h00, 8'h02, 8'h00, 8'h00);
    push_report(8'h00, 8'h70, 8'hd0, 8'h01);
    push_report(8'h00, 8'h02, 8'h00, 8'h00);
    push_report(8'h00, 8'h50, 8'h46, 8'h00);
    push_report(8'h00, 8'h02, 8'h00, 8'h00);
    push_report(8'h00, 8'h32, 8'h10, 8'h00);
    push_report(8'hff, 8'hff, 8'hff, 8'hff);
    push_report(8'h00, 8'h00, 8'h00, 8'h00);
    push_report(8'h00, 8'h00, 8'h00, 8'h00);
    wait_drained();

    // Random phases over modes, thresholds and idle patterns
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      mode = (ph % 2 == 0);
      if (ph < 4) thr = (ph == 0 || ph == 3) ? THR_W'(1) : THR_W'(127);
      else thr = THR_W'($urandom_range(127, 1));
      in_idle_pct   = 0;
      out_stall_pct = 0;
      write_reg(CFG_REPORT_MODE, THR_W'(mode));
      write_reg(CFG_STEP_THRESHOLD, thr);
      case (ph % 4)
        1: begin
          in_idle_pct = 67;
        end
        2: begin
          out_stall_pct = 67;
        end
        3: begin
          in_idle_pct   = 29;
          out_stall_pct = 29;
        end
        default: begin
        end
      endcase
      for (int i = 0; i < PHASE_ITEMS; i++)
        report_q.push_back(make_report(mode == MODE_ABSOLUTE));
      wait_drained();
    end

    in_idle_pct   = 0;
    out_stall_pct = 0;
    repeat (8) @(negedge clk);
    if (fail_cnt == 0 && step_q.size() == 0) begin
      $display("touch_strip_step_decoder_core: match");
    end else begin
      $display("touch_strip_step_decoder_core: mismatch");
    end
    $finish;
  end

endmodule

// File: sim.f
hw/rtl/tssd_pkg.sv
hw/rtl/tssd_decode.sv
hw/rtl/touch_strip_step_decoder_core.sv
hw/rtl/tssd_checker.sv
test/tb_top.sv
